// File: rtl/core/kfli_pkg.sv
package kfli_pkg;

    localparam int WORDS_PER_FRAME = 16;
    localparam int CH_W = 4;
    localparam int VAL_W = 32;
    localparam int FRAC_W = 17;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic signed [VAL_W-1:0] NEAR_ZERO_RAW = 32'sd6;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic [31:0] numer;
        logic [31:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [FRAC_W-1:0]   quot;
    } div_rsp_t;

endpackage

// File: rtl/core/kfli_ram.sv
module kfli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/kfli_div.sv
module kfli_div (
    input  logic               clk,
    input  logic               rst_n,
    input  kfli_pkg::div_req_t req,
    output kfli_pkg::div_rsp_t rsp
);

    // restoring divider, one quotient bit per cycle: (numer << 16) / denom
    localparam int STEPS = 48;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [47:0]      num_reg, num_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;

    assign trial = {rem_reg[31:0], num_reg[47]} - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next  = {req.numer, 16'h0000};
            rem_next  = '0;
            den_next  = req.denom;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                num_next = {num_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], num_reg[47]};
                num_next = {num_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // quotient is below 2^16 + 1 whenever dur > elapsed > 0; clamp anyway
    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (num_reg[47:17] != '0)
        begin
            rsp.quot = kfli_pkg::FRAC_ONE;
        end
        else
        begin
            rsp.quot = (num_reg[16:0] > kfli_pkg::FRAC_ONE) ? kfli_pkg::FRAC_ONE
                                                           : num_reg[16:0];
        end
    end

endmodule

// File: rtl/core/kfli_blend.sv
module kfli_blend (
    input  logic                               clk,
    input  logic [kfli_pkg::FRAC_W-1:0]        frac,
    input  logic signed [kfli_pkg::VAL_W-1:0]  cur,
    input  logic signed [kfli_pkg::VAL_W-1:0]  nxt,
    output logic signed [kfli_pkg::VAL_W-1:0]  blended
);

    // frac*cur + (1-frac)*nxt = nxt + frac*(cur-nxt); one multiply, registered
    logic signed [32:0] diff;
    logic signed [51:0] prod_reg;
    logic signed [52:0] sum;

    assign diff = 33'(cur) - 33'(nxt);

    always_ff @(posedge clk)
    begin
        prod_reg <= 52'(diff * $signed({1'b0, frac}));
    end

    assign sum = 53'(prod_reg) + ($signed(53'(nxt)) <<< 16) + 53'sd32768;
    assign blended = sum[47:16];

endmodule

// File: rtl/core/keyframe_linear_interpolator_core.sv
// channel    | dir | tdata bits (low first)                      | tuser/tlast
// s_axis     | in  | opcode[1:0] frame_index[7:2] channel[11:8]   | -
//            |     | word_value[43:12] time_step[74:44]          |
// m_axis     | out | out_channel[3:0] blended[35:4]              | tuser=still_running
//            |     |                                             | tlast=last
// cfg        | in  | frame_count[6:0] on cfg_we                  | -
// write/start/stop are handled in ST_IDLE; a tick that blends passes the duration
// checks ST_DUR1..ST_DUR3, a 48-step divide in ST_DIV when frac needs a division,
// then ST_RDC, ST_RDN, ST_MUL, ST_OUT per channel (two reads share one read port).
// A status tick shows its result right after the transfer, or after ST_DUR1 and ST_DUR2
// when the end is found after a frame advance. Reset clears control state; the table is
// undefined. m_axis stalls hold the sequencer in place until the result is taken.
module keyframe_linear_interpolator_core #(
    parameter int MAX_FRAMES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // opcode, frame_index, channel, word_value, time_step
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_channel, blended
    output logic        m_axis_tuser,   // still_running
    output logic        m_axis_tlast    // last
);

    localparam int DEPTH = MAX_FRAMES * kfli_pkg::WORDS_PER_FRAME;
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(MAX_FRAMES) > 0 ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DUR1  = 9'b000000010,
        ST_DUR2  = 9'b000000100,
        ST_DUR3  = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_RDC   = 9'b000100000,
        ST_RDN   = 9'b001000000,
        ST_MUL   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    // input field unpack
    kfli_pkg::opcode_t         op;
    logic [5:0]                in_frame;
    logic [3:0]                in_ch;
    logic [31:0]               in_word;
    logic [30:0]               in_step;
    assign op       = kfli_pkg::opcode_t'(s_axis_tdata[1:0]);
    assign in_frame = s_axis_tdata[7:2];
    assign in_ch    = s_axis_tdata[11:8];
    assign in_word  = s_axis_tdata[43:12];
    assign in_step  = s_axis_tdata[74:44];

    state_t          state_reg, state_next;
    logic [6:0]      fcount_reg;
    logic [31:0]     elapsed_reg, elapsed_next;
    logic [FW:0]     cur_reg, cur_next;
    logic            running_reg, running_next;
    logic [3:0]      ch_reg, ch_next;
    logic [16:0]     frac_reg, frac_next;
    logic [31:0]     curv_reg, curv_next;
    logic            adv_reg, adv_next;
    logic            ov_reg, ov_next;
    logic [31:0]     ob_reg, ob_next;
    logic [3:0]      och_reg, och_next;
    logic            orun_reg, orun_next, olast_reg, olast_next;

    logic [CW-1:0]   cnt;
    logic            few;
    logic            in_fire, out_fire;
    logic [32:0]     esum;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            fcount_reg <= cfg_wdata;
        end
    end

    assign cnt = (32'(fcount_reg) < MAX_FRAMES) ? CW'(fcount_reg) : CW'(MAX_FRAMES);
    // count below two, or no frame after the current one
    assign few = (cnt < CW'(2)) || (32'(cur_reg) >= 32'(cnt) - 32'd1);

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign esum = 33'(elapsed_reg) + 33'(in_step);

    // frame table: one write port, one read port shared by all reads
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [31:0]     rdata;
    logic [FW:0]     rframe;
    logic [3:0]      rch;

    assign we = in_fire && (op == kfli_pkg::OP_WRITE) && (32'(in_frame) < MAX_FRAMES);
    assign waddr = AW'({32'(in_frame), in_ch});
    assign raddr = AW'({32'(rframe), rch});

    kfli_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(in_word),
        .raddr(raddr), .rdata(rdata)
    );

    kfli_pkg::div_req_t dreq;
    kfli_pkg::div_rsp_t drsp;
    kfli_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [31:0] blended;
    kfli_blend u_blend (
        .clk(clk), .frac(frac_reg), .cur($signed(curv_reg)),
        .nxt($signed(rdata)), .blended(blended)
    );

    logic signed [31:0] dur;
    logic               near0;
    assign dur   = $signed(rdata);
    assign near0 = (dur <= kfli_pkg::NEAR_ZERO_RAW) && (dur >= -kfli_pkg::NEAR_ZERO_RAW);

    // read address follows the state; next frame word is held through the blend
    always_comb
    begin
        rframe = cur_reg;
        rch    = ch_reg;
        case (state_reg)
            ST_IDLE, ST_DUR1, ST_DUR2: rch = '0;
            ST_DUR3:                   rch = 4'd1;
            ST_RDC, ST_RDN, ST_MUL:    rframe = cur_reg + 1'b1;
            ST_OUT:                    rch = ch_reg + 4'd1;
            default:                   rframe = cur_reg;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        cur_next     = cur_reg;
        running_next = running_reg;
        ch_next      = ch_reg;
        frac_next    = frac_reg;
        curv_next    = curv_reg;
        adv_next     = adv_reg;
        ov_next      = ov_reg;
        ob_next      = ob_reg;
        och_next     = och_reg;
        orun_next    = orun_reg;
        olast_next   = olast_reg;
        dreq.start   = 1'b0;
        dreq.numer   = 32'(dur) - elapsed_reg;
        dreq.denom   = rdata;
        if (out_fire)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        kfli_pkg::OP_START:
                        begin
                            running_next = 1'b1;
                            cur_next     = '0;
                            elapsed_next = '0;
                        end
                        kfli_pkg::OP_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        kfli_pkg::OP_TICK:
                        begin
                            if (!running_reg || few)
                            begin
                                running_next = 1'b0;
                                ov_next = 1'b1; ob_next = '0; och_next = '0;
                                orun_next = 1'b0; olast_next = 1'b1;
                            end
                            else
                            begin
                                elapsed_next = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
                                state_next   = ST_DUR1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUR1:
            begin
                // duration of current frame on rdata
                if ($signed({1'b0, elapsed_reg}) >= 33'(dur))
                begin
                    cur_next     = cur_reg + 1'b1;
                    elapsed_next = '0;
                    adv_next     = 1'b1;
                end
                else
                begin
                    adv_next = 1'b0;
                end
                state_next = ST_DUR2;
            end
            ST_DUR2:
            begin
                if (few)
                begin
                    running_next = 1'b0;
                    ov_next = 1'b1; ob_next = '0; och_next = '0;
                    orun_next = 1'b0; olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DUR3;
                end
            end
            ST_DUR3:
            begin
                ch_next = 4'd1;
                if (near0 || elapsed_reg == '0)
                begin
                    frac_next  = kfli_pkg::FRAC_ONE;
                    state_next = ST_RDC;
                end
                else if ($signed(33'(dur)) <= $signed({1'b0, elapsed_reg}))
                begin
                    frac_next  = '0;
                    state_next = ST_RDC;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    frac_next  = drsp.quot;
                    state_next = ST_RDC;
                end
            end
            ST_RDC:
            begin
                // rdata holds current frame word, next read issued
                curv_next  = rdata;
                state_next = ST_RDN;
            end
            ST_RDN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (!ov_next)
                begin
                    ov_next    = 1'b1;
                    ob_next    = blended;
                    och_next   = ch_reg;
                    orun_next  = 1'b1;
                    olast_next = (ch_reg == 4'd15);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (olast_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = ST_RDC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            cur_reg     <= '0;
            running_reg <= 1'b0;
            ov_reg      <= 1'b0;
            ch_reg      <= '0;
            adv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            cur_reg     <= cur_next;
            running_reg <= running_next;
            ov_reg      <= ov_next;
            ch_reg      <= ch_next;
            adv_reg     <= adv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg  <= frac_next;
        curv_reg  <= curv_next;
        ob_reg    <= ob_next;
        och_reg   <= och_next;
        orun_reg  <= orun_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'b0000, ob_reg, och_reg};
    assign m_axis_tuser  = orun_reg;
    assign m_axis_tlast  = olast_reg;

`ifndef ASSERT_OFF
    // no new item while a result waits
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with result pending");
    // blended results always report running
    a_blend_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] != 4'd0) |-> m_axis_tuser)
        else $error("blended result without running");
    // divider only runs in the divide state
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide");
    // frame advance clears elapsed time
    a_adv_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUR2 && adv_reg) |-> elapsed_reg == '0)
        else $error("elapsed not cleared on advance");
`endif

endmodule

// File: tb/tb_keyframe_linear_interpolator_core.sv
`timescale 1ns / 100ps

module tb_keyframe_linear_interpolator_core;

    localparam int FRAMES = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        kfli_pkg::opcode_t op;
        bit [5:0]    frame;
        bit [3:0]    chan;
        bit [31:0]   word;
        bit [30:0]   step;
    } command_t;

    typedef struct {
        bit [3:0]    chan;
        bit [31:0]   value;
        bit          active;
        bit          tick_end;
    } sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [6:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // shadow of the block state
    logic signed [31:0] key_table [FRAMES*kfli_pkg::WORDS_PER_FRAME];
    bit [15:0]          loaded_words [FRAMES];
    bit [31:0]          elapsed;
    int unsigned        cur_frame;
    bit                 playing;
    bit [6:0]           frame_total;

    sample_t     pending_samples[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;

    keyframe_linear_interpolator_core #(.MAX_FRAMES(FRAMES)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    function automatic int unsigned usable_frames();
        return (frame_total < FRAMES) ? frame_total : FRAMES;
    endfunction

    function automatic longint key_word(input int unsigned f, input int unsigned ch);
        return longint'(key_table[f*kfli_pkg::WORDS_PER_FRAME + ch]);
    endfunction

    function automatic void push_status();
        sample_t s;
        s.chan = '0;
        s.value = '0;
        s.active = 1'b0;
        s.tick_end = 1'b1;
        pending_samples.push_back(s);
    endfunction

    // elapsed time after a tick, saturated to 32 bits
    function automatic bit [31:0] advance_time(input bit [30:0] step);
        bit [32:0] sum;
        sum = {1'b0, elapsed} + step;
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // expected samples of one tick: blend samples, or one status sample
    function automatic void predict_tick(input bit [30:0] step);
        int unsigned n;
        longint dur, e, frac, mix;
        sample_t s;
        if (!playing)
        begin
            push_status();
            return;
        end
        n = usable_frames();
        if (n < 2 || cur_frame >= n - 1)
        begin
            playing = 1'b0;
            push_status();
            return;
        end
        elapsed = advance_time(step);
        if (longint'(elapsed) >= key_word(cur_frame, 0))
        begin
            cur_frame++;
            elapsed = '0;
        end
        if (cur_frame >= n - 1)
        begin
            playing = 1'b0;
            push_status();
            return;
        end
        dur = key_word(cur_frame, 0);
        e = longint'(elapsed);
        if ((dur <= 6 && dur >= -6) || e == 0)
            frac = 65536;
        else if (dur <= e)
            frac = 0;
        else
        begin
            frac = ((dur - e) <<< 16) / dur;
            if (frac > 65536)
                frac = 65536;
        end
        for (int ch = 1; ch < kfli_pkg::WORDS_PER_FRAME; ch++)
        begin
            mix = frac * key_word(cur_frame, ch) + (65536 - frac) * key_word(cur_frame + 1, ch)
                + 32768;
            s.chan = ch[3:0];
            s.value = 32'(mix >>> 16);
            s.active = 1'b1;
            s.tick_end = (ch == kfli_pkg::WORDS_PER_FRAME - 1);
            pending_samples.push_back(s);
        end
    endfunction

    function automatic void apply_command(input command_t c);
        case (c.op)
            kfli_pkg::OP_WRITE:
            begin
                key_table[c.frame*kfli_pkg::WORDS_PER_FRAME + c.chan] = c.word;
                loaded_words[c.frame][c.chan] = 1'b1;
            end
            kfli_pkg::OP_START:
            begin
                playing = 1'b1;
                cur_frame = 0;
                elapsed = '0;
            end
            kfli_pkg::OP_STOP:
                playing = 1'b0;
            default:
                predict_tick(c.step);
        endcase
    endfunction

    // true when a tick reads only table words that were loaded
    function automatic bit tick_reads_loaded(input bit [30:0] step);
        int unsigned n, nf;
        if (!playing)
            return 1'b1;
        n = usable_frames();
        if (n < 2 || cur_frame >= n - 1)
            return 1'b1;
        if (!loaded_words[cur_frame][0])
            return 1'b0;
        nf = cur_frame;
        if (longint'(advance_time(step)) >= key_word(cur_frame, 0))
            nf++;
        if (nf >= n - 1)
            return 1'b1;
        return (&loaded_words[nf]) && (&loaded_words[nf + 1]);
    endfunction

    // one transfer on the input stream
    task automatic send(input command_t c);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'b0, c.step, c.word, c.chan, c.frame, c.op};
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        apply_command(c);
    endtask

    task automatic send_write(input int f, input int ch, input bit [31:0] v);
        command_t c;
        c.op = kfli_pkg::OP_WRITE;
        c.frame = f[5:0];
        c.chan = ch[3:0];
        c.word = v;
        c.step = 31'($urandom());
        send(c);
    endtask

    task automatic send_control(input kfli_pkg::opcode_t op);
        command_t c;
        c.op = op;
        c.frame = 6'($urandom());
        c.chan = 4'($urandom());
        c.word = $urandom();
        c.step = 31'($urandom());
        send(c);
    endtask

    // a tick that would read unloaded words becomes a rewind
    task automatic send_tick(input bit [30:0] step);
        command_t c;
        c.op = tick_reads_loaded(step) ? kfli_pkg::OP_TICK : kfli_pkg::OP_START;
        c.frame = 6'($urandom());
        c.chan = 4'($urandom());
        c.word = $urandom();
        c.step = step;
        send(c);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_total(input bit [6:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_total = v;
    endtask

    function automatic bit [31:0] random_duration();
        case ($urandom_range(0, 9))
            0: return 32'($urandom_range(0, 6));
            1: return -32'($urandom_range(1, 32'h20000));
            2: return $urandom();
            default: return 32'($urandom_range(7, 32'h30000));
        endcase
    endfunction

    function automatic bit [30:0] random_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'($urandom());
            2: return 31'h7FFF_FFFF;
            default: return 31'($urandom_range(1, 32'h18000));
        endcase
    endfunction

    // fill frames 0..5 with durations of every kind and extreme values
    task automatic test_load_frames();
        bit [31:0] dur [6];
        dur = '{32'h0003_0000, 32'd6, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'd3};
        for (int f = 0; f < 6; f++)
        begin
            send_write(f, 0, dur[f]);
            for (int ch = 1; ch < kfli_pkg::WORDS_PER_FRAME; ch++)
                send_write(f, ch, $urandom());
        end
        send_write(0, 1, 32'h7FFF_FFFF);
        send_write(1, 1, 32'h8000_0000);
        send_write(0, 2, 32'h8000_0000);
        send_write(1, 2, 32'h7FFF_FFFF);
        send_write(63, 15, 32'hFFFF_FFFF);
    endtask

    // special cases of the sequencer
    task automatic test_directed();
        set_frame_total(7'd0);
        send_tick(31'd1);
        send_control(kfli_pkg::OP_START);
        send_tick(31'd1);
        set_frame_total(7'd1);
        send_control(kfli_pkg::OP_START);
        send_tick(31'd0);
        set_frame_total(7'd4);
        send_control(kfli_pkg::OP_START);
        send_tick(31'd0);
        send_tick(31'h0001_0000);
        send_tick(31'h0002_0000);
        send_tick(31'd2);
        send_tick(31'd4);
        send_tick(31'd1);
        send_tick(31'h7FFF_FFFF);
        send_tick(31'h7FFF_FFFF);
        send_control(kfli_pkg::OP_STOP);
        send_tick(31'd5);
        set_frame_total(7'd127);
        send_control(kfli_pkg::OP_START);
        send_tick(31'h7FFF_FFFF);
        send_tick(31'h0001_0000);
    endtask

    // well-formed playback with random content, plus loose noise
    task automatic test_random_playback(input int items);
        int sent;
        int f;
        bit mid_done;
        bit [6:0] totals [8];
        totals = '{7'd2, 7'd3, 7'd5, 7'd8, 7'd64, 7'd127, 7'd1, 7'd6};
        sent = 0;
        mid_done = 1'b0;
        while (sent < items)
        begin
            if ($urandom_range(0, 4) == 0)
                set_frame_total(totals[$urandom_range(0, 7)]);
            if (!mid_done && sent >= items / 2)
            begin
                drain();
                mid_done = 1'b1;
            end
            if (sent > items - 40)
                quiet = 1'b1;
            case ($urandom_range(0, 9))
                0:
                begin
                    f = $urandom_range(0, 7);
                    send_write(f, 0, random_duration());
                    for (int ch = 1; ch < kfli_pkg::WORDS_PER_FRAME; ch++)
                        send_write(f, ch, $urandom());
                    sent += kfli_pkg::WORDS_PER_FRAME;
                end
                1:
                begin
                    send_write($urandom_range(0, 63), $urandom_range(0, 15), $urandom());
                    sent++;
                end
                2:
                begin
                    send_control(kfli_pkg::OP_STOP);
                    sent++;
                end
                3:
                begin
                    send_control(kfli_pkg::OP_START);
                    sent++;
                end
                default:
                begin
                    send_control(kfli_pkg::OP_START);
                    sent++;
                    repeat ($urandom_range(2, 8))
                    begin
                        send_tick(random_step());
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // result checking and output stall bursts
    initial
    begin : output_side
        sample_t exp_s;
        bit fire;
        bit [39:0] data;
        bit usr, lst;
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            fire = m_axis_tvalid && m_axis_tready;
            data = m_axis_tdata;
            usr = m_axis_tuser;
            lst = m_axis_tlast;
            @(posedge clk);
            if (fire)
            begin
                if (pending_samples.size() == 0)
                    report($sformatf("unexpected transfer chan %0d", data[3:0]));
                else
                begin
                    exp_s = pending_samples.pop_front();
                    if (data[3:0] !== exp_s.chan)
                        report($sformatf("chan %0d want %0d", data[3:0], exp_s.chan));
                    if (data[35:4] !== exp_s.value)
                        report($sformatf("chan %0d value %h want %h", exp_s.chan,
                            data[35:4], exp_s.value));
                    if (usr !== exp_s.active)
                        report($sformatf("chan %0d running %b want %b", exp_s.chan, usr,
                            exp_s.active));
                    if (lst !== exp_s.tick_end)
                        report($sformatf("chan %0d last %b want %b", exp_s.chan, lst,
                            exp_s.tick_end));
                end
            end
            if (quiet)
                m_axis_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 12);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        elapsed = '0;
        cur_frame = 0;
        playing = 1'b0;
        frame_total = '0;
        foreach (loaded_words[i])
            loaded_words[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_frames();
        test_directed();
        test_random_playback(100);
        drain();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
